FILE: rtl/core/hsv2rgb_pkg.sv
// Shared constants and types of the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  // Default number of fraction bits of the fixed-point inputs.
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Register stages from the input beat to the output register.
  localparam int unsigned NUM_STAGES = 5;

  // Hue offsets of the three color channels, in sixths of a turn.
  localparam int unsigned OFFSET_RED   = 5;
  localparam int unsigned OFFSET_GREEN = 3;
  localparam int unsigned OFFSET_BLUE  = 1;

  // Stage load strobes, one bit per pipeline stage, stage one in bit zero.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/hsv2rgb_if.sv
// Handshake interfaces for the HSV input beat and the RGB output beat.
`default_nettype none

interface hsv2rgb_in_if #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       range_error;

  modport source (output valid, red, green, blue, range_error, input ready);
  modport sink   (input valid, red, green, blue, range_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hsv2rgb_chan.sv
// One color channel of the converter: hue weight, products and 8-bit scaling.
`default_nettype none

module hsv2rgb_chan #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEFAULT,
  parameter int unsigned OFFSET    = hsv2rgb_pkg::OFFSET_RED
) (
  input  wire logic                    clk_i,
  input  wire hsv2rgb_pkg::stage_ctl_t ctl_i,
  input  wire logic [FRAC_BITS:0]      hue_i,   // stage one input
  input  wire logic [FRAC_BITS:0]      sat_i,   // stage two input
  input  wire logic [FRAC_BITS:0]      val_i,   // stage three input
  input  wire logic                    zero_i,  // stage five input
  output logic [7:0]                   chan_o
);

  localparam int unsigned KW  = FRAC_BITS + 4;
  localparam int unsigned PW  = 2 * FRAC_BITS + 2;
  localparam int unsigned YW  = 3 * FRAC_BITS + 2;
  localparam int unsigned ZW  = YW + 8;

  localparam logic [KW-1:0] OneK    = KW'(1) << FRAC_BITS;
  localparam logic [KW-1:0] ThreeK  = KW'(3) << FRAC_BITS;
  localparam logic [KW-1:0] FourK   = KW'(4) << FRAC_BITS;
  localparam logic [KW-1:0] SixK    = KW'(6) << FRAC_BITS;
  localparam logic [KW-1:0] OffsetK = KW'(OFFSET) << FRAC_BITS;
  localparam logic [PW-1:0] OneSq   = PW'(1) << (2 * FRAC_BITS);

  logic [KW-1:0]          k_raw;
  logic [KW-1:0]          k_mod;
  logic [KW-1:0]          k_rev;
  logic [FRAC_BITS:0]     m_d, m_q;
  logic [PW-1:0]          prod_sm;
  logic [PW-1:0]          t_full;
  logic [2*FRAC_BITS:0]   t_q;
  logic [PW-1:0]          ph_q;
  logic [2*FRAC_BITS:0]   pl_q;
  logic [YW-1:0]          y_q;
  logic [ZW-1:0]          z_scaled;
  logic [7:0]             chan_d, chan_q;

  // Stage one: position on the hue circle and the piecewise-linear weight.
  assign k_raw = OffsetK + KW'(hue_i) * KW'(6);
  assign k_mod = (k_raw >= SixK) ? (k_raw - SixK) : k_raw;
  assign k_rev = FourK - k_mod;

  always_comb begin
    if (k_mod < OneK) begin
      m_d = k_mod[FRAC_BITS:0];
    end else if (k_mod <= ThreeK) begin
      m_d = OneK[FRAC_BITS:0];
    end else if (k_mod < FourK) begin
      m_d = k_rev[FRAC_BITS:0];
    end else begin
      m_d = '0;
    end
  end

  // Stage two: t = 1.0^2 - s*m, exact with 2*FRAC_BITS fraction bits.
  assign prod_sm = PW'(sat_i) * PW'(m_q);
  assign t_full  = OneSq - prod_sm;

  // Stage five: 255*y by shift and subtract, keep the integer bits.
  assign z_scaled = {y_q, 8'b0} - ZW'(y_q);
  assign chan_d   = zero_i ? 8'b0 : z_scaled[3*FRAC_BITS+7 -: 8];

  // Pipeline registers, each loaded by its stage strobe.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      m_q <= m_d;
    end
    if (ctl_i.load[1]) begin
      t_q <= t_full[2*FRAC_BITS:0];
    end
    // Stage three: v*t split in two narrow products.
    if (ctl_i.load[2]) begin
      ph_q <= PW'(val_i) * PW'(t_q[2*FRAC_BITS:FRAC_BITS]);
      pl_q <= (2*FRAC_BITS+1)'(val_i) * (2*FRAC_BITS+1)'(t_q[FRAC_BITS-1:0]);
    end
    // Stage four: recombine into v*t with 3*FRAC_BITS fraction bits.
    if (ctl_i.load[3]) begin
      y_q <= {ph_q, {FRAC_BITS{1'b0}}} + YW'(pl_q);
    end
    if (ctl_i.load[4]) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

FILE: rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: handshake, range check and pipeline control.
//
// Converts one HSV pixel (unsigned fixed point, 2^FRAC_BITS = 1.0) into 8-bit
// RGB per beat. The block accepts a new pixel every clock cycle unless output
// back-pressure stalls it, and delivers each result in order. The five register
// stages are the hue weight, the saturation product, the brightness products,
// their recombination and the final scaling by 255 into the output register.
// A stage that holds a beat loads only when the stage after it moves on, so
// output back-pressure stalls the pipe without loss and empty slots are filled
// up. Any input above 1.0 yields range_error with all three colors at zero.
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  hsv2rgb_in_if.sink    hsv_i,
  hsv2rgb_out_if.source rgb_o
);

  localparam int unsigned NS = hsv2rgb_pkg::NUM_STAGES;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  hsv2rgb_pkg::stage_ctl_t ctl;
  logic [NS-1:0]      valid_q;
  logic [NS-1:0]      err_q;
  logic [NS-1:0]      valid_chain;
  logic [NS-1:0]      err_chain;
  logic               err_in;
  logic [FRAC_BITS:0] sat_s1_q;
  logic [FRAC_BITS:0] val_s1_q;
  logic [FRAC_BITS:0] val_s2_q;

  // A stage loads when it is empty or when the next stage takes its beat.
  always_comb begin
    ctl.load[NS-1] = !valid_q[NS-1] || rgb_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ctl.load[k] = !valid_q[k] || ctl.load[k+1];
    end
  end

  assign hsv_i.ready = ctl.load[0];

  // Range check on the incoming beat.
  assign err_in = (hsv_i.hue > One) || (hsv_i.saturation > One) ||
                  (hsv_i.brightness > One);

  assign valid_chain = {valid_q[NS-2:0], hsv_i.valid};
  assign err_chain   = {err_q[NS-2:0], err_in};

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ctl.load[k]) begin
          valid_q[k] <= valid_chain[k];
        end
      end
    end
  end

  // Shared payload: error flag, saturation and brightness delay lines.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (ctl.load[k]) begin
        err_q[k] <= err_chain[k];
      end
    end
    if (ctl.load[0]) begin
      sat_s1_q <= hsv_i.saturation;
      val_s1_q <= hsv_i.brightness;
    end
    if (ctl.load[1]) begin
      val_s2_q <= val_s1_q;
    end
  end

  hsv2rgb_chan #(
    .FRAC_BITS (FRAC_BITS),
    .OFFSET    (hsv2rgb_pkg::OFFSET_RED)
  ) u_chan_red (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .hue_i  (hsv_i.hue),
    .sat_i  (sat_s1_q),
    .val_i  (val_s2_q),
    .zero_i (err_q[NS-2]),
    .chan_o (rgb_o.red)
  );

  hsv2rgb_chan #(
    .FRAC_BITS (FRAC_BITS),
    .OFFSET    (hsv2rgb_pkg::OFFSET_GREEN)
  ) u_chan_green (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .hue_i  (hsv_i.hue),
    .sat_i  (sat_s1_q),
    .val_i  (val_s2_q),
    .zero_i (err_q[NS-2]),
    .chan_o (rgb_o.green)
  );

  hsv2rgb_chan #(
    .FRAC_BITS (FRAC_BITS),
    .OFFSET    (hsv2rgb_pkg::OFFSET_BLUE)
  ) u_chan_blue (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .hue_i  (hsv_i.hue),
    .sat_i  (sat_s1_q),
    .val_i  (val_s2_q),
    .zero_i (err_q[NS-2]),
    .chan_o (rgb_o.blue)
  );

  assign rgb_o.valid       = valid_q[NS-1];
  assign rgb_o.range_error = err_q[NS-1];

endmodule

`default_nettype wire

FILE: rtl/core/hsv2rgb_checker.sv
// Port-level checks on the HSV to RGB converter, bound to its top level.
`default_nettype none

module hsv2rgb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_i,
  input wire logic [7:0] green_i,
  input wire logic [7:0] blue_i,
  input wire logic       range_error_i
);

  // An out-of-range beat carries black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && range_error_i |-> red_i == 8'd0 && green_i == 8'd0 && blue_i == 8'd0)
    else $error("range error beat with nonzero color");

  // With the output register empty, the whole pipe can move, so input is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register is empty");

  // A ready output means the pipe advances and the input is ready too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i && in_valid_i |-> in_ready_i)
    else $error("input stalled while output is taken");

  // A stalled output beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i) && $stable(green_i)
      && $stable(blue_i) && $stable(range_error_i))
    else $error("stalled output beat changed");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (hsv_i.valid),
  .in_ready_i    (hsv_i.ready),
  .out_valid_i   (rgb_o.valid),
  .out_ready_i   (rgb_o.ready),
  .red_i         (rgb_o.red),
  .green_i       (rgb_o.green),
  .blue_i        (rgb_o.blue),
  .range_error_i (rgb_o.range_error)
);

`default_nettype wire
